>>> hdl/door_stepper_controller_core_macros.svh
// Assertion macros used by the door stepper controller top level.
`ifndef DOOR_STEPPER_CONTROLLER_CORE_MACROS_SVH
`define DOOR_STEPPER_CONTROLLER_CORE_MACROS_SVH

// Implication checked at every rising edge of clk outside reset.
`define DSC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define DSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/dsc_pkg.sv
// Types, constants and the half-step table of the door stepper controller.
`default_nettype none
package dsc_pkg;

	localparam int PHASES  = 8;
	localparam int PHASE_W = $clog2(PHASES);

	localparam int STEPS_W = 13;
	localparam int TICKS_W = 20;
	localparam int COILS_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [STEPS_W-1:0] HSPM_RESET   = 13'd4096;
	localparam logic [TICKS_W-1:0] AUTO_RESET   = 20'd10000;
	localparam logic [TICKS_W-1:0] FORCED_RESET = 20'd5000;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEPS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_CLOSE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCED_CLOSE = 2'd2;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_PRESENCE = 2'd1,
		ACT_FORCED   = 2'd2
	} action_t;

	typedef logic [PHASE_W-1:0] phase_t;

	typedef struct packed {
		logic                open_flag;
		logic                active;
		logic                opening;
		phase_t              phase;
		logic [STEPS_W-1:0]  left;
		logic                armed;
		logic [TICKS_W-1:0]  countdown;
		logic [COILS_W-1:0]  coils;
	} state_t;

	typedef struct packed {
		logic [STEPS_W-1:0] half_steps;
		logic [TICKS_W-1:0] auto_close;
		logic [TICKS_W-1:0] forced_close;
	} cfg_t;

	// Packed so that coils sits in the lowest bits of the output data.
	typedef struct packed {
		logic               rejected;
		logic               close_pending;
		logic               moving;
		logic               door_is_open;
		logic [COILS_W-1:0] coils;
	} result_t;

	localparam logic [COILS_W-1:0] HALF_STEP_TABLE [0:7] = '{
		4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9
	};

	function automatic logic [COILS_W-1:0] half_step(input phase_t ph);
		logic [2:0] idx;
		idx = 3'(ph);
		return HALF_STEP_TABLE[idx];
	endfunction

endpackage
`default_nettype wire

>>> hdl/dsc_cfg.sv
// Configuration registers of the door stepper controller.
`default_nettype none
module dsc_cfg
	import dsc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_steps   <= HSPM_RESET;
			cfg_q.auto_close   <= AUTO_RESET;
			cfg_q.forced_close <= FORCED_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_HALF_STEPS:   cfg_q.half_steps   <= cfg_wdata[STEPS_W-1:0];
				CFG_AUTO_CLOSE:   cfg_q.auto_close   <= cfg_wdata[TICKS_W-1:0];
				CFG_FORCED_CLOSE: cfg_q.forced_close <= cfg_wdata[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> hdl/dsc_step.sv
// Single-pass update of the door state for one request.
`default_nettype none
module dsc_step
	import dsc_pkg::*;
(
	input  wire state_t       cur,
	input  wire cfg_t         cfg,
	input  wire logic [1:0]   action,
	input  wire logic         value,
	output state_t            nxt,
	output result_t           res
);

	localparam phase_t PH_LAST = phase_t'(PHASES - 1);

	state_t st;
	logic   rej;

	always_comb begin
		st  = cur;
		rej = 1'b0;
		unique case (action)
			ACT_TICK: begin
				if (cur.active) begin
					if (cur.left != '0) begin
						st.coils = half_step(cur.phase);
						if (cur.opening)
							st.phase = (cur.phase == PH_LAST) ? '0 : cur.phase + 1'b1;
						else
							st.phase = (cur.phase == '0) ? PH_LAST : cur.phase - 1'b1;
						st.left = cur.left - 1'b1;
					end
					if (st.left == '0) begin
						st.active    = 1'b0;
						st.open_flag = cur.opening;
					end
				end else if (cur.armed) begin
					if (cur.countdown <= TICKS_W'(1)) begin
						st.countdown = '0;
						st.armed     = 1'b0;
						if (cur.open_flag) begin
							st.active  = 1'b1;
							st.opening = 1'b0;
							st.phase   = PH_LAST;
							st.left    = cfg.half_steps;
							st.coils   = '0;
						end
					end else begin
						st.countdown = cur.countdown - 1'b1;
					end
				end
			end
			ACT_PRESENCE: begin
				if (cur.active) begin
					rej = 1'b1;
				end else if (value) begin
					st.armed     = 1'b0;
					st.countdown = '0;
					if (!cur.open_flag) begin
						st.active  = 1'b1;
						st.opening = 1'b1;
						st.phase   = '0;
						st.left    = cfg.half_steps;
						st.coils   = '0;
					end
				end else if (!cur.armed) begin
					st.armed     = 1'b1;
					st.countdown = cfg.auto_close;
				end
			end
			ACT_FORCED: begin
				if (cur.active) begin
					rej = 1'b1;
				end else if (value) begin
					if (!cur.open_flag) begin
						st.active  = 1'b1;
						st.opening = 1'b1;
						st.phase   = '0;
						st.left    = cfg.half_steps;
						st.coils   = '0;
					end
					// A forced open always ends with the forced close countdown armed.
					st.armed     = 1'b1;
					st.countdown = cfg.forced_close;
				end else begin
					st.armed     = 1'b0;
					st.countdown = '0;
					if (cur.open_flag) begin
						st.active  = 1'b1;
						st.opening = 1'b0;
						st.phase   = PH_LAST;
						st.left    = cfg.half_steps;
						st.coils   = '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign nxt               = st;
	assign res.coils         = st.coils;
	assign res.door_is_open  = st.open_flag;
	assign res.moving        = st.active;
	assign res.close_pending = st.armed;
	assign res.rejected      = rej;

endmodule
`default_nettype wire

>>> hdl/door_stepper_controller_core.sv
// Top level of the door stepper controller: handshakes, state and result registers.
//
// Half-step sequencer for a four-coil door stepper. Each request (a one-millisecond
// tick, a presence report or a forced open/close command, selected by s_tuser) yields
// exactly one result carrying the coil pattern and the door status after that request.
// A request is taken into an input register, the door state is updated by a single
// pass of logic, and the result register is loaded from that pass when it is empty or
// being emptied, so one request is taken every clock cycle
// while the output side keeps up. Presence and forced requests that arrive during a
// motion are ignored and flagged as rejected. Configuration writes are taken at any
// time but must only be made while no request is in flight.
`default_nettype none
`include "door_stepper_controller_core_macros.svh"
module door_stepper_controller_core
	import dsc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [0] value, [7:1] zero
	input  wire logic [1:0]            s_tuser,   // [1:0] action
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [3:0] coils, [4] door_is_open, [5] moving, [6] close_pending, [7] rejected
	output logic [7:0]                 m_tdata,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic       v_s1;
	logic [1:0] action_s1;
	logic       value_s1;
	logic       out_valid_q;
	result_t    result_q;
	state_t     state_q;
	state_t     state_nxt;
	result_t    result_nxt;
	cfg_t       cfg;
	logic       advance;

	dsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dsc_step u_step (
		.cur    (state_q),
		.cfg    (cfg),
		.action (action_s1),
		.value  (value_s1),
		.nxt    (state_nxt),
		.res    (result_nxt)
	);

	// The input stage moves on whenever the result register is empty or being emptied.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			value_s1  <= s_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else if (advance) begin
			out_valid_q <= v_s1;
			if (v_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1)
			result_q <= result_nxt;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

	`DSC_ASSERT_IMP(a_still_no_steps, !state_q.active, state_q.left == '0, "steps left while still")
	`DSC_ASSERT_IMP(a_disarmed_zero, !state_q.armed, state_q.countdown == '0, "countdown left when disarmed")
	`DSC_ASSERT_IMP(a_coil_pattern, state_q.coils != '0, ($countones(state_q.coils) == 1) || ($countones(state_q.coils) == 2), "coil pattern not a half step")
	`DSC_ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, v_s1, "accepted request lost")

endmodule
`default_nettype wire
